/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl
// no dependencies; the checks drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: check failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/rwps_pkg.sv */
// types, codes and byte-lane helpers for the riff/wave pcm stream parser
// no dependencies
package rwps_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_SIZE,
    PH_WAVE,
    PH_HEADER,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_DONE,
    KIND_FAIL
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_NOT_RIFF,
    ERR_NOT_WAVE,
    ERR_RATE,
    ERR_DATA_FIRST,
    ERR_FORMAT,
    ERR_NO_DATA
  } err_t;

  typedef enum logic {
    REG_EXPECTED_RATE
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] sample;
    err_t               error_code;
    logic               last;
  } out_word_t;

  function automatic logic [31:0] lane32(logic [31:0] w, logic [1:0] idx, logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (idx)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

  function automatic logic [23:0] lane24(logic [23:0] w, logic [1:0] idx, logic [7:0] b);
    logic [23:0] r;
    r = w;
    case (idx)
      2'd0:    r[7:0]   = b;
      2'd1:    r[15:8]  = b;
      2'd2:    r[23:16] = b;
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] lane16(logic [15:0] w, logic idx, logic [7:0] b);
    logic [15:0] r;
    r = w;
    if (idx) begin
      r[15:8] = b;
    end else begin
      r[7:0] = b;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/riff_wave_pcm_stream_parser.sv */
// riff/wave pcm stream parser: one file byte per word in, samples and status out
// each result word is written into the result queue when its byte is accepted and is offered from there in order
// throughput: one byte per cycle; in_ready is low while three or more words wait in
// the 4-word result queue, so the input stalls only when the receiver falls behind
// reset (rst_n low, synchronous) clears parser state, queue and expected_rate
// depends on rwps_pkg and assert_macros.svh
`include "assert_macros.svh"

module riff_wave_pcm_stream_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rwps_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output rwps_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rwps_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [31:0] tag_shift_r, tag_shift_nxt;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [15:0] channel_count_r, channel_count_nxt;
  logic [31:0] file_rate_r, file_rate_nxt;
  logic [15:0] sample_bits_r, sample_bits_nxt;
  logic        format_seen_r, format_seen_nxt;
  logic [17:0] frame_idx_r, frame_idx_nxt;
  logic [23:0] assembly_r, assembly_nxt;
  logic [31:0] expected_rate_r;

  out_word_t             oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic [OQ_CNT_W-1:0]   count_r;

  logic        in_fire, out_fire, cfg_wr;
  logic [7:0]  b;
  logic [4:0]  bc_inc;
  logic [31:0] cl_tmp, cl_dec;
  logic        bps3;
  logic [1:0]  bps;
  logic [17:0] fs, frame_inc;
  logic [23:0] asm_new;
  logic        emit_smp, fin_req;
  err_t        fin_err;
  logic [23:0] smp;
  out_word_t   res_a, res_b;
  logic        push_a, push_b;
  logic        eos_fire, smp_head, smp_ok;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign b        = in_word.data_byte;
  assign bc_inc   = {1'b0, byte_count_r} + 5'd1;
  assign bps3     = (sample_bits_r == 16'd24);
  assign bps      = bps3 ? 2'd3 : 2'd2;
  assign fs       = {1'b0, channel_count_r, 1'b0} + (bps3 ? {2'b00, channel_count_r} : 18'd0);
  assign frame_inc = frame_idx_r + 18'd1;
  assign cl_dec   = (chunk_length_r != 32'd0) ? chunk_length_r - 32'd1 : 32'd0;
  assign asm_new  = (frame_idx_r < {16'd0, bps}) ? lane24(assembly_r, frame_idx_r[1:0], b)
                                                 : assembly_r;
  assign smp      = bps3 ? asm_new : {asm_new[15:0], 8'h00};

  // next state of the parser
  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r;
    tag_shift_nxt     = tag_shift_r;
    chunk_length_nxt  = chunk_length_r;
    channel_count_nxt = channel_count_r;
    file_rate_nxt     = file_rate_r;
    sample_bits_nxt   = sample_bits_r;
    format_seen_nxt   = format_seen_r;
    frame_idx_nxt     = frame_idx_r;
    assembly_nxt      = assembly_r;
    cl_tmp            = chunk_length_r;
    emit_smp          = 1'b0;
    fin_req           = 1'b0;
    fin_err           = ERR_NONE;
    if (in_fire) begin
      unique case (phase_r)
        PH_RIFF: begin
          tag_shift_nxt  = {tag_shift_r[23:0], b};
          byte_count_nxt = bc_inc[3:0];
          if (bc_inc == 5'd4) begin
            byte_count_nxt = 4'd0;
            if (tag_shift_nxt != TAG_RIFF) begin
              fin_req = 1'b1;
              fin_err = ERR_NOT_RIFF;
            end else begin
              phase_nxt = PH_SIZE;
            end
          end
        end
        PH_SIZE: begin
          byte_count_nxt = bc_inc[3:0];
          if (bc_inc == 5'd4) begin
            byte_count_nxt = 4'd0;
            tag_shift_nxt  = 32'd0;
            phase_nxt      = PH_WAVE;
          end
        end
        PH_WAVE: begin
          tag_shift_nxt  = {tag_shift_r[23:0], b};
          byte_count_nxt = bc_inc[3:0];
          if (bc_inc == 5'd4) begin
            byte_count_nxt = 4'd0;
            if (tag_shift_nxt != TAG_WAVE) begin
              fin_req = 1'b1;
              fin_err = ERR_NOT_WAVE;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end
        end
        PH_HEADER: begin
          cl_tmp = (byte_count_r == 4'd0) ? 32'd0 : chunk_length_r;
          if (byte_count_r < 4'd4) begin
            tag_shift_nxt = {tag_shift_r[23:0], b};
          end else begin
            cl_tmp = lane32(cl_tmp, byte_count_r[1:0], b);
          end
          chunk_length_nxt = cl_tmp;
          byte_count_nxt   = bc_inc[3:0];
          if (bc_inc == 5'd8) begin
            byte_count_nxt = 4'd0;
            if (tag_shift_nxt == TAG_FMT) begin
              phase_nxt = PH_FMT;
            end else if (tag_shift_nxt == TAG_DATA) begin
              if (!format_seen_r) begin
                fin_req = 1'b1;
                fin_err = ERR_DATA_FIRST;
              end else if ((sample_bits_r != 16'd16 && !bps3) || channel_count_r == 16'd0) begin
                fin_req = 1'b1;
                fin_err = ERR_FORMAT;
              end else if (cl_tmp < {14'd0, fs}) begin
                fin_req = 1'b1;
                fin_err = ERR_NONE;
              end else begin
                frame_idx_nxt = 18'd0;
                assembly_nxt  = 24'd0;
                phase_nxt     = PH_DATA;
              end
            end else begin
              phase_nxt = (cl_tmp != 32'd0) ? PH_SKIP : PH_HEADER;
            end
          end
        end
        PH_FMT: begin
          case (byte_count_r) inside
            4'd2, 4'd3: channel_count_nxt = lane16(channel_count_r, byte_count_r[0], b);
            4'd4, 4'd5, 4'd6, 4'd7: file_rate_nxt = lane32(file_rate_r, byte_count_r[1:0], b);
            4'd14, 4'd15: sample_bits_nxt = lane16(sample_bits_r, byte_count_r[0], b);
            default: ;
          endcase
          byte_count_nxt = bc_inc[3:0];
          if (bc_inc == 5'd16) begin
            byte_count_nxt = 4'd0;
            if (expected_rate_r != 32'd0 && file_rate_r != expected_rate_r) begin
              fin_req = 1'b1;
              fin_err = ERR_RATE;
            end else begin
              format_seen_nxt = 1'b1;
              if (chunk_length_r > 32'd16) begin
                chunk_length_nxt = chunk_length_r - 32'd16;
                phase_nxt        = PH_SKIP;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end
          end
        end
        PH_SKIP: begin
          chunk_length_nxt = cl_dec;
          if (cl_dec == 32'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_DATA: begin
          chunk_length_nxt = cl_dec;
          assembly_nxt     = asm_new;
          frame_idx_nxt    = frame_inc;
          if (frame_inc >= fs) begin
            emit_smp      = 1'b1;
            frame_idx_nxt = 18'd0;
            assembly_nxt  = 24'd0;
            if (cl_dec < {14'd0, fs}) begin
              fin_req = 1'b1;
              fin_err = ERR_NONE;
            end
          end
        end
        PH_DONE: ;
        default: ;
      endcase
      if (fin_req) begin
        phase_nxt = PH_DONE;
      end
      if (in_word.end_of_stream) begin
        if (phase_nxt != PH_DONE) begin
          fin_req = 1'b1;
          unique case (phase_nxt) inside
            PH_DATA:          fin_err = ERR_NONE;
            PH_RIFF:          fin_err = ERR_NOT_RIFF;
            PH_SIZE, PH_WAVE: fin_err = ERR_NOT_WAVE;
            default:          fin_err = ERR_NO_DATA;
          endcase
        end
        phase_nxt         = PH_RIFF;
        byte_count_nxt    = 4'd0;
        tag_shift_nxt     = 32'd0;
        chunk_length_nxt  = 32'd0;
        channel_count_nxt = 16'd1;
        file_rate_nxt     = 32'd0;
        sample_bits_nxt   = 16'd16;
        format_seen_nxt   = 1'b0;
        frame_idx_nxt     = 18'd0;
        assembly_nxt      = 24'd0;
      end
    end
  end

  // result words for the queue
  always_comb begin
    res_a  = '0;
    res_b  = '0;
    push_a = 1'b0;
    push_b = 1'b0;
    if (emit_smp) begin
      res_a.kind   = KIND_SAMPLE;
      res_a.sample = smp;
      push_a       = 1'b1;
    end
    if (fin_req) begin
      if (push_a) begin
        res_b.kind       = (fin_err == ERR_NONE) ? KIND_DONE : KIND_FAIL;
        res_b.error_code = fin_err;
        res_b.last       = 1'b1;
        push_b           = 1'b1;
      end else begin
        res_a.kind       = (fin_err == ERR_NONE) ? KIND_DONE : KIND_FAIL;
        res_a.error_code = fin_err;
        res_a.last       = 1'b1;
        push_a           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_RIFF;
      byte_count_r    <= 4'd0;
      tag_shift_r     <= 32'd0;
      chunk_length_r  <= 32'd0;
      channel_count_r <= 16'd1;
      file_rate_r     <= 32'd0;
      sample_bits_r   <= 16'd16;
      format_seen_r   <= 1'b0;
      frame_idx_r     <= 18'd0;
      assembly_r      <= 24'd0;
    end else begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      tag_shift_r     <= tag_shift_nxt;
      chunk_length_r  <= chunk_length_nxt;
      channel_count_r <= channel_count_nxt;
      file_rate_r     <= file_rate_nxt;
      sample_bits_r   <= sample_bits_nxt;
      format_seen_r   <= format_seen_nxt;
      frame_idx_r     <= frame_idx_nxt;
      assembly_r      <= assembly_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_rate_r <= 32'd0;
    end else if (cfg_wr && reg_idx_t'(paddr[2]) == REG_EXPECTED_RATE) begin
      expected_rate_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (reg_idx_t'(paddr[2]) == REG_EXPECTED_RATE) ? expected_rate_r : 32'd0;

  // result queue
  always_ff @(posedge clk) begin
    if (push_a) begin
      oq_r[wr_ptr_r] <= res_a;
    end
    if (push_b) begin
      oq_r[wr_ptr_r + OQ_PTR_W'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(out_fire);
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(push_a) + OQ_PTR_W'(push_b);
      count_r  <= count_r + OQ_CNT_W'(push_a) + OQ_CNT_W'(push_b) - OQ_CNT_W'(out_fire);
    end
  end

  assign in_ready  = (count_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_word  = oq_r[rd_ptr_r];

  assign eos_fire = in_fire && in_word.end_of_stream;
  assign smp_head = out_valid && out_word.kind == KIND_SAMPLE;
  assign smp_ok   = !out_word.last && out_word.error_code == ERR_NONE;

  `ASSERT_RST(a_queue_bound, clk, rst_n, count_r <= OQ_CNT_W'(OQ_DEPTH))
  `ASSERT_RST(a_data_needs_fmt, clk, rst_n, (phase_r == PH_DATA) |-> format_seen_r)
  `ASSERT_RST(a_eos_restart, clk, rst_n, eos_fire |=> (phase_r == PH_RIFF && byte_count_r == 4'd0))
  `ASSERT_RST(a_sample_word, clk, rst_n, smp_head |-> smp_ok)
  `ASSERT_RST(a_stall_keeps, clk, rst_n, (out_valid && !out_ready) |=> out_valid)

endmodule
